@@ rtl/core/abcp_pkg.sv @@
// Shared types, codes and constants of the aging block cache policy core.
`timescale 1ns / 1ps
`default_nettype none

package abcp_pkg;

    localparam int unsigned TABLE_DEPTH_DEF = 32;

    localparam int unsigned ID_W      = 16;
    localparam int unsigned LIFE_W    = 8;
    localparam int unsigned STATUS_W  = 3;
    localparam int unsigned CFG_W     = 16;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [LIFE_W-1:0] LIFETIME_RESET = 8'd30;
    localparam logic [ID_W-1:0]   PINNED_RESET   = 16'd1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LIFETIME_MAX = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_PINNED_BLOCK = 1'b1;

    // Result kinds
    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_EVICT  = 1'b1;

    // Access status codes
    localparam logic [STATUS_W-1:0] STS_UNAVAIL       = 3'd0;
    localparam logic [STATUS_W-1:0] STS_PINNED_HIT    = 3'd1;
    localparam logic [STATUS_W-1:0] STS_HIT           = 3'd2;
    localparam logic [STATUS_W-1:0] STS_LOADED        = 3'd3;
    localparam logic [STATUS_W-1:0] STS_HIT_NOSTR     = 3'd4;
    localparam logic [STATUS_W-1:0] STS_LOADED_NOSTR  = 3'd5;
    localparam logic [STATUS_W-1:0] STS_TABLE_FULL    = 3'd6;
    localparam logic [STATUS_W-1:0] STS_EVICT_REPORT  = 3'd0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_EVICT
    } state_t;

    typedef enum logic [1:0] {
        CH_HOLD,
        CH_LOOKUP,
        CH_EVICT
    } chain_op_t;

    typedef struct packed {
        logic              valid;
        logic              flag;
        logic [ID_W-1:0]   block;
        logic [LIFE_W-1:0] life;
    } entry_t;

    typedef struct packed {
        chain_op_t         op;
        logic [ID_W-1:0]   id;
        logic [LIFE_W-1:0] life_max;
        logic              lookup_en;
        logic              in_range;
    } chain_cmd_t;

    typedef struct packed {
        chain_op_t         op;
        logic [ID_W-1:0]   id;
        logic [LIFE_W-1:0] life_max;
        logic              insert;
        logic              age;
    } cell_ctl_t;

    typedef struct packed {
        logic            hit;
        logic            full;
        logic            will_evict;
        logic            any_flag;
        logic            evict_more;
        logic [ID_W-1:0] evict_id;
    } chain_sts_t;

endpackage

`default_nettype wire

@@ rtl/core/abcp_cell.sv @@
// One table cell: holds a resident entry, ages it and hands it to its neighbors.
`timescale 1ns / 1ps
`default_nettype none

module abcp_cell
    import abcp_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire cell_ctl_t ctl,
    input  wire logic      left_after,
    input  wire entry_t    left_aged,
    input  wire logic      left_seen,
    input  wire entry_t    right_ent,
    output logic           after,
    output entry_t         aged,
    output entry_t         ent,
    output logic           seen,
    output logic           sel,
    output logic           match,
    output logic           cand
);

    logic              valid_reg;
    logic              flag_reg;
    logic [ID_W-1:0]   block_reg;
    logic [LIFE_W-1:0] life_reg;
    entry_t            ent_next;
    entry_t            fresh;

    assign ent   = '{valid: valid_reg, flag: flag_reg, block: block_reg, life: life_reg};
    assign match = valid_reg && (block_reg == ctl.id);
    assign cand  = valid_reg && !match && (life_reg <= LIFE_W'(1));
    // new id goes at or before this cell in ascending order
    assign after = !valid_reg || (block_reg > ctl.id);
    assign seen  = left_seen || flag_reg;
    assign sel   = flag_reg && !left_seen;
    assign fresh = '{valid: 1'b1, flag: 1'b0, block: ctl.id, life: ctl.life_max};

    always_comb
    begin
        aged = ent;
        if (ctl.age && valid_reg)
        begin
            if (match)
            begin
                aged.life = ctl.life_max;
            end
            else if (life_reg <= LIFE_W'(1))
            begin
                aged.life = '0;
                aged.flag = 1'b1;
            end
            else
            begin
                aged.life = life_reg - LIFE_W'(1);
            end
        end
    end

    always_comb
    begin
        ent_next = ent;
        case (ctl.op)
            CH_LOOKUP:
            begin
                if (ctl.insert && left_after)
                begin
                    ent_next = left_aged;
                end
                else if (ctl.insert && after)
                begin
                    ent_next = fresh;
                end
                else
                begin
                    ent_next = aged;
                end
            end
            CH_EVICT:
            begin
                // close the gap: this cell and all after the reported one shift down
                if (seen)
                begin
                    ent_next = right_ent;
                end
            end
            default:
            begin
                ent_next = ent;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            flag_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= ent_next.valid;
            flag_reg  <= ent_next.flag;
        end
    end

    always_ff @(posedge clk)
    begin
        block_reg <= ent_next.block;
        life_reg  <= ent_next.life;
    end

endmodule

`default_nettype wire

@@ rtl/core/abcp_chain.sv @@
// Row of table cells kept sorted by block id, with hit, full and eviction reduction.
`timescale 1ns / 1ps
`default_nettype none

module abcp_chain
    import abcp_pkg::*;
#(
    parameter int unsigned DEPTH = TABLE_DEPTH_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire chain_cmd_t cmd,
    output chain_sts_t      sts
);

    logic      after_lnk [DEPTH+1];
    entry_t    aged_lnk  [DEPTH+1];
    logic      seen_lnk  [DEPTH+1];
    entry_t    ent_lnk   [DEPTH+1];
    logic      sel_w     [DEPTH];
    logic      match_w   [DEPTH];
    logic      cand_w    [DEPTH];
    cell_ctl_t ctl;
    logic      hit;
    logic      full;
    logic      cand_any;
    logic      more;
    logic [ID_W-1:0] evict_id;

    assign after_lnk[0]   = 1'b0;
    assign aged_lnk[0]    = '0;
    assign seen_lnk[0]    = 1'b0;
    assign ent_lnk[DEPTH] = '0;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            abcp_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctl        (ctl),
                .left_after (after_lnk[gi]),
                .left_aged  (aged_lnk[gi]),
                .left_seen  (seen_lnk[gi]),
                .right_ent  (ent_lnk[gi+1]),
                .after      (after_lnk[gi+1]),
                .aged       (aged_lnk[gi+1]),
                .ent        (ent_lnk[gi]),
                .seen       (seen_lnk[gi+1]),
                .sel        (sel_w[gi]),
                .match      (match_w[gi]),
                .cand       (cand_w[gi])
            );
        end
    endgenerate

    always_comb
    begin
        hit      = 1'b0;
        cand_any = 1'b0;
        more     = 1'b0;
        evict_id = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            hit      = hit | match_w[i];
            cand_any = cand_any | cand_w[i];
            more     = more | (ent_lnk[i].flag & ~sel_w[i]);
            if (sel_w[i])
            begin
                evict_id = evict_id | ent_lnk[i].block;
            end
        end
    end

    assign full = ent_lnk[DEPTH-1].valid;

    always_comb
    begin
        ctl.op       = cmd.op;
        ctl.id       = cmd.id;
        ctl.life_max = cmd.life_max;
        ctl.insert   = cmd.lookup_en && !hit && !full;
        ctl.age      = cmd.lookup_en && (hit || !full) && cmd.in_range;
    end

    always_comb
    begin
        sts.hit        = hit;
        sts.full       = full;
        sts.will_evict = ctl.age && cand_any;
        sts.any_flag   = seen_lnk[DEPTH];
        sts.evict_more = more;
        sts.evict_id   = evict_id;
    end

endmodule

`default_nettype wire

@@ rtl/core/aging_block_cache_policy_core.sv @@
// Top level of the aging block cache policy core: control, config and result register.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one access item: req_id,
//   available, string_in_range. Output channel (out_valid / out_stall) carries
//   result items: one access status item, then one eviction report per entry
//   whose lifetime ran out, in ascending block id order; last marks the final
//   item of an access.
//   The status item is loaded into the output register from the lookup state
//   that follows acceptance of the input item. Each access passes through the
//   idle and lookup states, and no new item is taken until the core is idle;
//   evictions leave the single result register one per cycle unless stalled.
//   The table is a row of TABLE_DEPTH cells kept sorted by block id; lookup,
//   insert and aging of all cells happen in the same cycle, evictions close the gap
//   by shifting the cells after the reported one down by one.
//   Reset empties the table at once (no clearing pass) and loads lifetime_max
//   to 30 and pinned_block to 1. Write config through cfg_we / cfg_index /
//   cfg_data only while the core is idle.
//   While out_stall is high, the pending item holds in the output register and
//   the core holds its work; in_stall stays high until the access is done.
`timescale 1ns / 1ps
`default_nettype none

module aging_block_cache_policy_core
    import abcp_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [ID_W-1:0]      req_id,
    input  wire logic                 available,
    input  wire logic                 string_in_range,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic                      result_kind,
    output logic [STATUS_W-1:0]       status,
    output logic [ID_W-1:0]           reported_id,
    output logic                      last
);

    state_t              state_reg;
    state_t              state_next;

    logic [LIFE_W-1:0]   life_max_reg;
    logic [ID_W-1:0]     pinned_reg;

    // accepted item
    logic [ID_W-1:0]     id_reg;
    logic                avail_reg;
    logic                range_reg;

    // result register
    logic                out_valid_reg;
    logic                out_valid_next;
    logic                kind_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [ID_W-1:0]     rid_reg;
    logic                last_reg;
    logic                kind_next;
    logic [STATUS_W-1:0] status_next;
    logic [ID_W-1:0]     rid_next;
    logic                last_next;
    logic                load_out;

    logic                out_free;
    logic                is_pinned;
    logic [STATUS_W-1:0] acc_status;
    chain_cmd_t          cmd;
    chain_sts_t          sts;

    // register is free when empty or being taken this cycle
    assign out_free  = !out_valid_reg || !out_stall;
    assign is_pinned = (id_reg == pinned_reg);

    abcp_chain #(
        .DEPTH (TABLE_DEPTH)
    ) u_chain (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .sts   (sts)
    );

    // access status from lookup outcome
    always_comb
    begin
        if (!avail_reg)
        begin
            acc_status = STS_UNAVAIL;
        end
        else if (is_pinned)
        begin
            acc_status = STS_PINNED_HIT;
        end
        else if (sts.hit)
        begin
            acc_status = range_reg ? STS_HIT : STS_HIT_NOSTR;
        end
        else if (!sts.full)
        begin
            acc_status = range_reg ? STS_LOADED : STS_LOADED_NOSTR;
        end
        else
        begin
            acc_status = STS_TABLE_FULL;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                if (out_free)
                begin
                    state_next = sts.will_evict ? ST_EVICT : ST_IDLE;
                end
            end
            ST_EVICT:
            begin
                if (out_free && !sts.evict_more)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs of the controller
    always_comb
    begin
        in_stall      = 1'b1;
        cmd.op        = CH_HOLD;
        cmd.id        = id_reg;
        cmd.life_max  = life_max_reg;
        cmd.lookup_en = avail_reg && !is_pinned;
        cmd.in_range  = range_reg;
        load_out      = 1'b0;
        kind_next     = KIND_STATUS;
        status_next   = acc_status;
        rid_next      = id_reg;
        last_next     = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
            end
            ST_LOOKUP:
            begin
                if (out_free)
                begin
                    cmd.op    = CH_LOOKUP;
                    load_out  = 1'b1;
                    last_next = !sts.will_evict;
                end
            end
            ST_EVICT:
            begin
                if (out_free)
                begin
                    cmd.op      = CH_EVICT;
                    load_out    = 1'b1;
                    kind_next   = KIND_EVICT;
                    status_next = STS_EVICT_REPORT;
                    rid_next    = sts.evict_id;
                    last_next   = !sts.evict_more;
                end
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            life_max_reg  <= LIFETIME_RESET;
            pinned_reg    <= PINNED_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_LIFETIME_MAX: life_max_reg <= cfg_data[LIFE_W-1:0];
                    REG_PINNED_BLOCK: pinned_reg   <= cfg_data[ID_W-1:0];
                    default:          life_max_reg <= life_max_reg;
                endcase
            end
        end
    end

    // capture the item on accept
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            id_reg    <= req_id;
            avail_reg <= available;
            range_reg <= string_in_range;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            kind_reg   <= kind_next;
            status_reg <= status_next;
            rid_reg    <= rid_next;
            last_reg   <= last_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign result_kind = kind_reg;
    assign status      = status_reg;
    assign reported_id = rid_reg;
    assign last        = last_reg;

    // an eviction phase always has a marked entry left to report
    a_evict_has_flag : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EVICT) |-> sts.any_flag)
        else $error("eviction phase without marked entry");

    // no marked entry survives an access
    a_idle_no_flag : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !sts.any_flag)
        else $error("marked entry left after access");

    // a status item that is not last is followed by eviction reports
    a_status_not_last : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (kind_reg == KIND_STATUS) && !last_reg) |->
        (state_reg == ST_EVICT))
        else $error("status not last but no eviction pending");

endmodule

`default_nettype wire

@@ bench/residency_table_checker.sv @@
// Checker for the aging block cache policy core: predicts and compares result items.
`timescale 1ns / 1ps

module residency_table_checker
    import abcp_pkg::*;
#(
    parameter int unsigned DEPTH = TABLE_DEPTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  logic [ID_W-1:0]      req_id,
    input  logic                 available,
    input  logic                 string_in_range,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  logic                 result_kind,
    input  logic [STATUS_W-1:0]  status,
    input  logic [ID_W-1:0]      reported_id,
    input  logic                 last,
    output int                   fail_count,
    output int                   pending_results,
    output int                   access_count,
    output int                   eviction_count,
    output int                   full_count
);

    typedef struct packed {
        logic                kind;
        logic [STATUS_W-1:0] code;
        logic [ID_W-1:0]     id;
        logic                last;
    } result_t;

    logic [LIFE_W-1:0] life_max;
    logic [ID_W-1:0]   pinned_id;
    logic              slot_used [DEPTH];
    logic [ID_W-1:0]   slot_id   [DEPTH];
    logic [LIFE_W-1:0] slot_life [DEPTH];

    result_t expected_results [$];

    // Apply one access to the shadow table and queue the result items it causes.
    function automatic void predict_access(input logic [ID_W-1:0] id, input logic avail,
                                           input logic in_range);
        int                  hit;
        int                  free_slot;
        int                  pick;
        logic [STATUS_W-1:0] code;
        logic                expired [DEPTH];
        result_t             res;

        hit       = -1;
        free_slot = -1;
        if (!avail)
            code = STS_UNAVAIL;
        else if (id == pinned_id)
            code = STS_PINNED_HIT;
        else
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                if (slot_used[i] && slot_id[i] == id && hit < 0)
                    hit = i;
                if (!slot_used[i] && free_slot < 0)
                    free_slot = i;
            end
            if (hit >= 0)
                code = in_range ? STS_HIT : STS_HIT_NOSTR;
            else if (free_slot >= 0)
            begin
                hit                  = free_slot;
                slot_used[hit]       = 1'b1;
                slot_id[hit]         = id;
                slot_life[hit]       = life_max;
                code = in_range ? STS_LOADED : STS_LOADED_NOSTR;
            end
            else
            begin
                code = STS_TABLE_FULL;
                full_count++;
            end
        end

        res = '{KIND_STATUS, code, id, 1'b0};
        expected_results = {expected_results, res};

        if (hit >= 0 && in_range)
        begin
            // age every other entry; saturate at zero and mark the expired ones
            for (int i = 0; i < DEPTH; i++)
            begin
                expired[i] = 1'b0;
                if (slot_used[i])
                begin
                    if (i == hit)
                        slot_life[i] = life_max;
                    else if (slot_life[i] <= 1)
                    begin
                        slot_life[i] = '0;
                        expired[i]   = 1'b1;
                    end
                    else
                        slot_life[i] = slot_life[i] - 1'b1;
                end
            end
            // report evictions in ascending block id order
            pick = 0;
            while (pick >= 0)
            begin
                pick = -1;
                for (int i = 0; i < DEPTH; i++)
                    if (expired[i] && (pick < 0 || slot_id[i] < slot_id[pick]))
                        pick = i;
                if (pick >= 0)
                begin
                    expired[pick]   = 1'b0;
                    slot_used[pick] = 1'b0;
                    res = '{KIND_EVICT, STS_EVICT_REPORT, slot_id[pick], 1'b0};
                    expected_results = {expected_results, res};
                    eviction_count++;
                end
            end
        end

        expected_results[expected_results.size() - 1].last = 1'b1;
    endfunction

    // Compare one accepted result item against the oldest expectation.
    function automatic void check_result();
        result_t want;

        if (expected_results.size() == 0)
        begin
            fail_count++;
            $display("%0t: unexpected result kind=%0d status=%0d id=%h last=%0d",
                     $time, result_kind, status, reported_id, last);
        end
        else
        begin
            want = expected_results.pop_front();
            if (result_kind !== want.kind || status !== want.code ||
                reported_id !== want.id || last !== want.last)
            begin
                fail_count++;
                $display("%0t: result mismatch: expected kind=%0d status=%0d id=%h last=%0d",
                         $time, want.kind, want.code, want.id, want.last);
                $display("%0t:                  actual kind=%0d status=%0d id=%h last=%0d",
                         $time, result_kind, status, reported_id, last);
            end
        end
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            life_max  = LIFETIME_RESET;
            pinned_id = PINNED_RESET;
            for (int i = 0; i < DEPTH; i++)
                slot_used[i] = 1'b0;
            expected_results.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_LIFETIME_MAX: life_max  = cfg_data[LIFE_W-1:0];
                    REG_PINNED_BLOCK: pinned_id = cfg_data[ID_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                access_count++;
                predict_access(req_id, available, string_in_range);
            end
            if (out_valid && !out_stall)
                check_result();
        end
        pending_results = expected_results.size();
    end

endmodule

@@ bench/aging_block_cache_policy_core_test.sv @@
// Testbench top for the aging block cache policy core: stimulus, stalls and verdict.
`timescale 1ns / 1ps

module aging_block_cache_policy_core_test;
    import abcp_pkg::*;

    // Cycles with no item moving on either channel before the run is declared hung.
    // Worst honest stretch is a long output stall or input gap plus a
    // config pause; this is many times that.
    localparam int IDLE_LIMIT = 2000;
    localparam int POOL_SIZE  = 40;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    logic [ID_W-1:0]      req_id;
    logic                 available;
    logic                 string_in_range;
    logic                 out_valid;
    logic                 out_stall;
    logic                 result_kind;
    logic [STATUS_W-1:0]  status;
    logic [ID_W-1:0]      reported_id;
    logic                 last;

    int fail_count;
    int pending_results;
    int access_count;
    int eviction_count;
    int full_count;
    int reg_writes;
    int idle_cycles;

    // When set, the matching side runs without gaps or stalls for a while.
    bit in_quiet;
    bit out_quiet;

    // Ids that well-formed traffic draws from, so that hits and aging happen.
    logic [ID_W-1:0] id_pool [POOL_SIZE];
    logic [ID_W-1:0] cur_pinned;

    aging_block_cache_policy_core dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .req_id          (req_id),
        .available       (available),
        .string_in_range (string_in_range),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .result_kind     (result_kind),
        .status          (status),
        .reported_id     (reported_id),
        .last            (last)
    );

    residency_table_checker table_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .req_id          (req_id),
        .available       (available),
        .string_in_range (string_in_range),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .result_kind     (result_kind),
        .status          (status),
        .reported_id     (reported_id),
        .last            (last),
        .fail_count      (fail_count),
        .pending_results (pending_results),
        .access_count    (access_count),
        .eviction_count  (eviction_count),
        .full_count      (full_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Gap before an item: mostly none, sometimes short, rarely long.
    function automatic int pick_gap();
        int r;

        r = $urandom_range(0, 99);
        if (in_quiet || r < 55)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(4, 25);
    endfunction

    // Offer one item and hold it until the core takes it. Enter and leave at a
    // falling edge; valid stays high on exit so a back-to-back item needs only
    // one assignment in the next step.
    task automatic send_access(input logic [ID_W-1:0] id, input logic avail,
                               input logic in_range);
        int gap;

        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid        <= 1'b1;
        req_id          <= id;
        available       <= avail;
        string_in_range <= in_range;
        // in_stall is read before the edge's updates land, i.e. as the core saw it
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Drop valid and wait until every expected result has come back, then let
    // the core settle so a register write finds it idle.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_results != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Write one config register; the core latches it at the next rising edge.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
        reg_writes++;
        if (index == REG_PINNED_BLOCK)
            cur_pinned = data[ID_W-1:0];
    endtask

    // One random item. Most are well-formed lookups of pool ids with the string
    // in range; the rest hit the pinned id or are pure noise. A non-negative
    // fill index walks the pool in order so the table fills up.
    task automatic send_random_access(input int fill_index);
        int              r;
        logic [ID_W-1:0] id;
        logic            avail;
        logic            in_range;

        // occasionally switch between bursty and gap-free stretches
        if ($urandom_range(0, 9) == 0)
            in_quiet = ~in_quiet;
        if ($urandom_range(0, 9) == 0)
            out_quiet = ~out_quiet;

        r = $urandom_range(0, 99);
        if (fill_index >= 0 && fill_index < POOL_SIZE)
        begin
            id       = id_pool[fill_index];
            avail    = 1'b1;
            in_range = 1'b1;
        end
        else if (r < 80)
        begin
            id       = id_pool[$urandom_range(0, POOL_SIZE - 1)];
            avail    = 1'b1;
            in_range = ($urandom_range(0, 9) != 0);
        end
        else if (r < 88)
        begin
            id       = cur_pinned;
            avail    = 1'($urandom_range(0, 1));
            in_range = 1'($urandom_range(0, 1));
        end
        else
        begin
            id       = ID_W'($urandom_range(0, 65535));
            avail    = 1'($urandom_range(0, 1));
            in_range = 1'($urandom_range(0, 1));
        end
        send_access(id, avail, in_range);
    endtask

    // Output backpressure: short stalls now and then, a few long ones, no new
    // ones while out_quiet holds.
    initial
    begin
        int stall_left;
        int r;

        out_stall  = 1'b0;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
                stall_left--;
            else
            begin
                r = $urandom_range(0, 99);
                if (!out_quiet && r < 25)
                    stall_left = (r < 3) ? $urandom_range(10, 40) : $urandom_range(1, 3);
            end
            out_stall <= (stall_left > 0);
        end
    end

    // Hang detector: any accepted item on either side restarts the count.
    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        int              phase;
        int              count;
        int              r;
        logic [LIFE_W-1:0] life;
        logic [ID_W-1:0] pinned;

        // every input known from time zero; reset held, then released at a falling edge
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = REG_LIFETIME_MAX;
        cfg_data        = '0;
        in_valid        = 1'b0;
        req_id          = '0;
        available       = 1'b0;
        string_in_range = 1'b0;
        in_quiet        = 1'b0;
        out_quiet       = 1'b0;
        reg_writes      = 0;
        cur_pinned      = PINNED_RESET;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part at reset config (lifetime 30, pinned id 1).
        send_access(16'd1, 1'b0, 1'b1);       // pinned id but unavailable
        send_access(16'd1, 1'b1, 1'b0);       // pinned hit, string missing
        send_access(16'd1, 1'b1, 1'b1);       // pinned hit
        send_access(16'h0000, 1'b1, 1'b1);    // load lowest id
        send_access(16'hFFFF, 1'b1, 1'b0);    // load highest id, string missing: no aging
        send_access(16'h0000, 1'b1, 1'b1);    // hit, ages the other entry
        send_access(16'hFFFF, 1'b1, 1'b0);    // hit, string missing
        send_access(16'hFFFF, 1'b0, 1'b1);    // resident but unavailable

        // Lifetime 1: two entries run out together, reported lowest id first.
        drain_results();
        write_reg(REG_LIFETIME_MAX, 16'd1);
        send_access(16'd300, 1'b1, 1'b1);
        send_access(16'd200, 1'b1, 1'b0);
        send_access(16'd100, 1'b1, 1'b1);

        // Lifetime 0: a freshly loaded entry dies on the next aging step.
        drain_results();
        write_reg(REG_LIFETIME_MAX, 16'd0);
        send_access(16'd400, 1'b1, 1'b0);
        send_access(16'h0000, 1'b1, 1'b1);

        // Pin an id that already sits in the table: lookups must ignore the entry.
        drain_results();
        write_reg(REG_PINNED_BLOCK, 16'hFFFF);
        send_access(16'hFFFF, 1'b1, 1'b1);
        send_access(16'hFFFF, 1'b0, 1'b0);
        drain_results();
        write_reg(REG_PINNED_BLOCK, 16'h0000);
        send_access(16'h0000, 1'b1, 1'b0);

        // Random phases, one register setting each. The first phase uses a long
        // lifetime and walks the pool so the table fills and reports table full.
        for (phase = 0; phase < 6; phase++)
        begin
            drain_results();
            foreach (id_pool[i])
            begin
                if (phase == 0 || $urandom_range(0, 1) == 1)
                begin
                    r = $urandom_range(0, 15);
                    if (r == 0)
                        id_pool[i] = 16'h0000;
                    else if (r == 1)
                        id_pool[i] = 16'hFFFF;
                    else
                        id_pool[i] = ID_W'($urandom_range(0, 65535));
                end
            end
            case (phase)
                0: begin life = 8'd255; pinned = ID_W'($urandom_range(0, 65535)); count = 45; end
                1: begin life = 8'd4;   pinned = 16'h0000;                 count = 25; end
                2: begin life = 8'd1;   pinned = 16'hFFFF;                 count = 20; end
                3: begin life = 8'd0;   pinned = id_pool[$urandom_range(0, POOL_SIZE - 1)];
                         count = 15; end
                4: begin life = LIFETIME_RESET; pinned = PINNED_RESET;     count = 25; end
                default: begin life = 8'd12; pinned = ID_W'($urandom_range(0, 65535));
                         count = 20; end
            endcase
            write_reg(REG_LIFETIME_MAX, {{(CFG_W - LIFE_W){1'b0}}, life});
            write_reg(REG_PINNED_BLOCK, pinned);
            in_quiet  = ($urandom_range(0, 3) == 0);
            out_quiet = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < count; k++)
                send_random_access(phase == 0 ? k : -1);
        end

        // Wait out every expected result, then a margin for stray ones.
        drain_results();
        repeat (20) @(negedge clk);

        $display("Run covered %0d accesses over %0d register writes, with %0d evictions",
                 access_count, reg_writes, eviction_count);
        $display("and %0d table-full statuses under random gaps and output stalls.",
                 full_count);
        if (fail_count == 0 && pending_results == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/abcp_pkg.sv
rtl/core/abcp_cell.sv
rtl/core/abcp_chain.sv
rtl/core/aging_block_cache_policy_core.sv
bench/residency_table_checker.sv
bench/aging_block_cache_policy_core_test.sv
